### hdl/hsd_pkg.sv
// package of the huffman stream decoder: sizing constants, result codes and
// the enum types of the control path; used by hsd_node_store, the top level and the testbench
package hsd_pkg;

    localparam int MAX_SYMBOLS_DEF = 256;
    localparam int BYTE_BITS       = 8;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_TOO_LARGE = 2'd1;
    localparam logic [1:0] ST_BAD_TREE  = 2'd2;

    typedef enum logic [2:0] {
        PH_SIZE_LO,
        PH_SIZE_HI,
        PH_PAD,
        PH_LIST,
        PH_TREE,
        PH_DATA,
        PH_HALT
    } t_phase;

    typedef enum logic [1:0] {
        S_IDLE,
        S_BITS,
        S_FLUSH
    } t_state;

endpackage

### hdl/hsd_in_if.sv
// input channel of the huffman stream decoder: one stream byte per item
// standalone, no dependencies
interface hsd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;
    logic       final_byte;

    modport source(output valid, stream_byte, final_byte, input ready);
    modport sink(input valid, stream_byte, final_byte, output ready);
endinterface

### hdl/hsd_out_if.sv
// output channel of the huffman stream decoder: one decoded symbol per item
// standalone, no dependencies
interface hsd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;
    logic [1:0] status;
    logic       run_last;

    modport source(output valid, symbol, status, run_last, input ready);
    modport sink(input valid, symbol, status, run_last, output ready);
endinterface

### hdl/hsd_node_store.sv
// node store of the code tree: per-node leaf flag and symbol, plus the right
// child record of each internal node; registered reads, uses hsd_pkg
module hsd_node_store #(
    parameter int MAX_SYMBOLS = hsd_pkg::MAX_SYMBOLS_DEF,
    localparam int NW = $clog2(2 * MAX_SYMBOLS)
) (
    input  logic          i_clk,
    input  logic          i_node_we,
    input  logic [NW-1:0] i_node_waddr,
    input  logic          i_node_wleaf,
    input  logic [7:0]    i_node_wsym,
    input  logic          i_right_we,
    input  logic [NW-1:0] i_right_waddr,
    input  logic [NW-1:0] i_right_widx,
    input  logic          i_right_wleaf,
    input  logic [7:0]    i_right_wsym,
    input  logic [NW-1:0] i_raddr,
    output logic          o_left_leaf,
    output logic [7:0]    o_left_sym,
    output logic [NW-1:0] o_right_idx,
    output logic          o_right_leaf,
    output logic [7:0]    o_right_sym
);
    localparam int DEPTH = 2 * MAX_SYMBOLS;

    logic [8:0]      node_mem  [DEPTH];
    logic [NW+8:0]   right_mem [DEPTH];
    logic [8:0]      r_node_rd;
    logic [NW+8:0]   r_right_rd;
    logic [NW-1:0]   left_addr;

    // left child of an internal node is always the next node in preorder
    assign left_addr = i_raddr + NW'(1);

    always_ff @(posedge i_clk) begin
        if (i_node_we) begin
            node_mem[i_node_waddr] <= {i_node_wleaf, i_node_wsym};
        end
        if (i_right_we) begin
            right_mem[i_right_waddr] <= {i_right_widx, i_right_wleaf, i_right_wsym};
        end
        r_node_rd  <= node_mem[left_addr];
        r_right_rd <= right_mem[i_raddr];
    end

    assign o_left_leaf  = r_node_rd[8];
    assign o_left_sym   = r_node_rd[7:0];
    assign o_right_idx  = r_right_rd[NW+8:9];
    assign o_right_leaf = r_right_rd[8];
    assign o_right_sym  = r_right_rd[7:0];
endmodule

### hdl/huffman_stream_decoder.sv
// huffman stream decoder top level: header parser, tree builder and tree walker
// uses hsd_pkg, hsd_in_if, hsd_out_if and hsd_node_store
//
// Usage:
//   i_in takes one stream byte per item with final_byte on the last byte of a
//   stream. o_out gives decoded symbols; run_last marks the last result that an
//   input byte caused, and a bad header or tree gives one result with nonzero
//   status, after which input is dropped up to the next final byte.
//   Header bytes (size low, size high, pad count, symbol list) are handled as
//   they are accepted. A tree or data byte is accepted, then its code bits are
//   examined one per step of the bit loop, then its last result is handed out;
//   a tree bit that closes a right subtree with an internal node takes a second
//   step, and the first data bit after the tree can wait for the node store
//   read.
//   The bit rate is set by the walk loop: each step reads the node store at the
//   current node and the next step needs that answer.
//   Each result waits in a pending register before it moves to o_out. A stalled
//   receiver holds o_out; the block keeps one more result in the pending
//   register and then pauses the bit loop until o_out is taken.
//   Reset (synchronous, active low) returns the control state to the start of
//   a stream; the memories need no clearing.
module huffman_stream_decoder #(
    parameter int MAX_SYMBOLS = hsd_pkg::MAX_SYMBOLS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hsd_in_if.sink    i_in,
    hsd_out_if.source o_out
);
    localparam int NW    = $clog2(2 * MAX_SYMBOLS);
    localparam int CW    = $clog2(MAX_SYMBOLS + 1);
    localparam int LW    = $clog2(MAX_SYMBOLS);
    localparam int NODES = 2 * MAX_SYMBOLS - 1;

    hsd_pkg::t_state r_state, n_state;
    hsd_pkg::t_phase r_phase, n_phase;
    logic [7:0]    r_size_lo, n_size_lo;
    logic [CW-1:0] r_alpha, n_alpha;
    logic [2:0]    r_pad, n_pad;
    logic [CW-1:0] r_placed, n_placed;
    logic [CW-1:0] r_sp, n_sp;
    logic [NW-1:0] r_nfree, n_nfree;
    logic [NW-1:0] r_cur, n_cur;
    logic          r_prev_leaf, n_prev_leaf;
    logic          r_root_leaf, n_root_leaf;
    logic          r_sub, n_sub;
    logic [7:0]    r_byte, n_byte;
    logic          r_last, n_last;
    logic [2:0]    r_bit, n_bit;
    logic [3:0]    r_nbits, n_nbits;
    logic          r_pend_v, n_pend_v;
    logic [7:0]    r_pend_sym, n_pend_sym;
    logic [1:0]    r_pend_st, n_pend_st;
    logic          r_out_v, n_out_v;
    logic [7:0]    r_out_sym, n_out_sym;
    logic [1:0]    r_out_st, n_out_st;
    logic          r_out_last, n_out_last;
    logic          r_rd_ok;

    logic [7:0]    sym_list [MAX_SYMBOLS];
    logic [NW-1:0] stack_mem [MAX_SYMBOLS];
    logic [7:0]    r_sl;
    logic [NW-1:0] r_top;

    logic          list_we;
    logic          push;
    logic          node_we, right_we;
    logic [NW-1:0] right_waddr, right_widx;
    logic          node_wleaf, right_wleaf;
    logic [7:0]    node_wsym, right_wsym;
    logic          left_leaf, right_leaf;
    logic [7:0]    left_sym, right_sym;
    logic [NW-1:0] right_idx;

    logic          out_free, accept, bit_v, go, consumed;
    logic          emit_v, pop, internal, has_child, c_leaf;
    logic [7:0]    emit_sym, c_sym;
    logic [1:0]    emit_st;
    logic [NW-1:0] c_idx;
    logic [15:0]   size16;
    logic [LW-1:0] top_addr;

    hsd_node_store #(.MAX_SYMBOLS(MAX_SYMBOLS)) u_nodes (
        .i_clk        (i_clk),
        .i_node_we    (node_we),
        .i_node_waddr (r_nfree),
        .i_node_wleaf (node_wleaf),
        .i_node_wsym  (node_wsym),
        .i_right_we   (right_we),
        .i_right_waddr(right_waddr),
        .i_right_widx (right_widx),
        .i_right_wleaf(right_wleaf),
        .i_right_wsym (right_wsym),
        .i_raddr      (n_cur),
        .o_left_leaf  (left_leaf),
        .o_left_sym   (left_sym),
        .o_right_idx  (right_idx),
        .o_right_leaf (right_leaf),
        .o_right_sym  (right_sym)
    );

    assign out_free       = !r_out_v || o_out.ready;
    assign i_in.ready     = (r_state == hsd_pkg::S_IDLE);
    assign accept         = i_in.valid && i_in.ready;
    assign o_out.valid    = r_out_v;
    assign o_out.symbol   = r_out_sym;
    assign o_out.status   = r_out_st;
    assign o_out.run_last = r_out_last;
    assign size16         = {i_in.stream_byte, r_size_lo};
    assign bit_v          = r_byte[7];
    assign top_addr       = LW'(n_sp - CW'(1));

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_size_lo   = r_size_lo;
        n_alpha     = r_alpha;
        n_pad       = r_pad;
        n_placed    = r_placed;
        n_sp        = r_sp;
        n_nfree     = r_nfree;
        n_cur       = r_cur;
        n_prev_leaf = r_prev_leaf;
        n_root_leaf = r_root_leaf;
        n_sub       = r_sub;
        n_byte      = r_byte;
        n_last      = r_last;
        n_bit       = r_bit;
        n_nbits     = r_nbits;
        n_pend_v    = r_pend_v;
        n_pend_sym  = r_pend_sym;
        n_pend_st   = r_pend_st;
        n_out_v     = r_out_v && !o_out.ready;
        n_out_sym   = r_out_sym;
        n_out_st    = r_out_st;
        n_out_last  = r_out_last;
        list_we     = 1'b0;
        push        = 1'b0;
        node_we     = 1'b0;
        node_wleaf  = bit_v;
        node_wsym   = bit_v ? r_sl : 8'd0;
        right_we    = 1'b0;
        right_waddr = r_nfree;
        right_widx  = '0;
        right_wleaf = 1'b0;
        right_wsym  = 8'd0;
        emit_v      = 1'b0;
        emit_sym    = 8'd0;
        emit_st     = hsd_pkg::ST_OK;
        go          = 1'b0;
        consumed    = 1'b0;
        pop         = 1'b0;
        internal    = (r_cur != '0) || !r_root_leaf;
        has_child   = 1'b0;
        c_leaf      = 1'b0;
        c_sym       = 8'd0;
        c_idx       = '0;

        unique case (r_state)
            hsd_pkg::S_IDLE: begin
                if (accept) begin
                    n_byte = i_in.stream_byte;
                    n_last = i_in.final_byte;
                    unique case (r_phase)
                        hsd_pkg::PH_SIZE_LO: begin
                            n_size_lo = i_in.stream_byte;
                            n_phase   = hsd_pkg::PH_SIZE_HI;
                        end
                        hsd_pkg::PH_SIZE_HI: begin
                            if (size16 > 16'(MAX_SYMBOLS)) begin
                                n_alpha    = '0;
                                n_phase    = hsd_pkg::PH_HALT;
                                n_pend_v   = 1'b1;
                                n_pend_sym = 8'd0;
                                n_pend_st  = hsd_pkg::ST_TOO_LARGE;
                                n_state    = hsd_pkg::S_FLUSH;
                            end else begin
                                n_alpha = CW'(size16);
                                n_phase = hsd_pkg::PH_PAD;
                            end
                        end
                        hsd_pkg::PH_PAD: begin
                            n_pad    = (i_in.stream_byte > 8'd7) ? 3'd7
                                                                 : i_in.stream_byte[2:0];
                            n_placed = '0;
                            n_phase  = (r_alpha == '0) ? hsd_pkg::PH_DATA
                                                       : hsd_pkg::PH_LIST;
                        end
                        hsd_pkg::PH_LIST: begin
                            list_we  = 1'b1;
                            n_placed = r_placed + CW'(1);
                            if (n_placed >= r_alpha) begin
                                n_placed = '0;
                                n_sp     = '0;
                                n_nfree  = '0;
                                n_sub    = 1'b0;
                                n_phase  = hsd_pkg::PH_TREE;
                            end
                        end
                        hsd_pkg::PH_TREE, hsd_pkg::PH_DATA: begin
                            n_bit   = 3'd0;
                            n_nbits = i_in.final_byte ? 4'(hsd_pkg::BYTE_BITS) - {1'b0, r_pad}
                                                      : 4'(hsd_pkg::BYTE_BITS);
                            n_state = hsd_pkg::S_BITS;
                        end
                        default: begin
                        end
                    endcase
                    if (i_in.final_byte && n_state == hsd_pkg::S_IDLE) begin
                        n_phase  = hsd_pkg::PH_SIZE_LO;
                        n_alpha  = '0;
                        n_pad    = 3'd0;
                        n_placed = '0;
                        n_sp     = '0;
                        n_nfree  = '0;
                        n_cur    = '0;
                    end
                end
            end

            hsd_pkg::S_BITS: begin
                go = !(r_pend_v && !out_free)
                     && (r_phase != hsd_pkg::PH_DATA || r_rd_ok);
                if (go) begin
                    consumed = 1'b1;
                    if (r_phase == hsd_pkg::PH_TREE) begin
                        pop = !r_sub && (r_nfree != '0) && r_prev_leaf;
                        if ({1'b0, r_nfree} >= (NW+1)'(NODES)
                            || (pop && r_sp == '0)) begin
                            emit_v  = 1'b1;
                            emit_st = hsd_pkg::ST_BAD_TREE;
                            n_phase = hsd_pkg::PH_HALT;
                        end else if (pop && !bit_v) begin
                            // close the pending right branch first, build the node on the next step of the bit loop
                            consumed    = 1'b0;
                            right_we    = 1'b1;
                            right_waddr = r_top;
                            right_widx  = r_nfree;
                            n_sp        = r_sp - CW'(1);
                            n_sub       = 1'b1;
                        end else begin
                            n_sub = 1'b0;
                            if (pop) begin
                                right_we    = 1'b1;
                                right_waddr = r_top;
                                right_widx  = r_nfree;
                                right_wleaf = bit_v;
                                right_wsym  = node_wsym;
                                n_sp        = r_sp - CW'(1);
                            end
                            if (bit_v) begin
                                node_we     = 1'b1;
                                n_nfree     = r_nfree + NW'(1);
                                n_prev_leaf = 1'b1;
                                n_placed    = r_placed + CW'(1);
                                if (r_nfree == '0) begin
                                    n_root_leaf = 1'b1;
                                end
                                if (n_placed >= r_alpha) begin
                                    n_phase = hsd_pkg::PH_DATA;
                                    n_cur   = '0;
                                end
                            end else if (r_sp >= CW'(MAX_SYMBOLS)) begin
                                emit_v  = 1'b1;
                                emit_st = hsd_pkg::ST_BAD_TREE;
                                n_phase = hsd_pkg::PH_HALT;
                            end else begin
                                node_we     = 1'b1;
                                right_we    = 1'b1;
                                push        = 1'b1;
                                n_sp        = r_sp + CW'(1);
                                n_nfree     = r_nfree + NW'(1);
                                n_prev_leaf = 1'b0;
                                if (r_nfree == '0) begin
                                    n_root_leaf = 1'b0;
                                end
                            end
                        end
                    end else if (r_phase == hsd_pkg::PH_DATA && r_nfree != '0) begin
                        if (!bit_v) begin
                            has_child = internal
                                && ({1'b0, r_cur} + (NW+1)'(1) < {1'b0, r_nfree});
                            c_leaf = left_leaf;
                            c_sym  = left_sym;
                            c_idx  = r_cur + NW'(1);
                        end else begin
                            has_child = internal && (right_idx != '0);
                            c_leaf = right_leaf;
                            c_sym  = right_sym;
                            c_idx  = right_idx;
                        end
                        if (!has_child) begin
                            n_cur = '0;
                        end else if (c_leaf) begin
                            emit_v   = 1'b1;
                            emit_sym = c_sym;
                            n_cur    = '0;
                        end else begin
                            n_cur = c_idx;
                        end
                    end
                    if (emit_v) begin
                        if (r_pend_v) begin
                            n_out_v    = 1'b1;
                            n_out_sym  = r_pend_sym;
                            n_out_st   = r_pend_st;
                            n_out_last = 1'b0;
                        end
                        n_pend_v   = 1'b1;
                        n_pend_sym = emit_sym;
                        n_pend_st  = emit_st;
                    end
                    if (consumed) begin
                        n_bit  = r_bit + 3'd1;
                        n_byte = {r_byte[6:0], 1'b0};
                        if ({1'b0, r_bit} + 4'd1 == r_nbits
                            || n_phase == hsd_pkg::PH_HALT) begin
                            n_state = hsd_pkg::S_FLUSH;
                        end
                    end
                end
            end

            hsd_pkg::S_FLUSH: begin
                if (!r_pend_v || out_free) begin
                    if (r_pend_v) begin
                        n_out_v    = 1'b1;
                        n_out_sym  = r_pend_sym;
                        n_out_st   = r_pend_st;
                        n_out_last = 1'b1;
                        n_pend_v   = 1'b0;
                    end
                    n_state = hsd_pkg::S_IDLE;
                    if (r_last) begin
                        n_phase  = hsd_pkg::PH_SIZE_LO;
                        n_alpha  = '0;
                        n_pad    = 3'd0;
                        n_placed = '0;
                        n_sp     = '0;
                        n_nfree  = '0;
                        n_cur    = '0;
                    end
                end
            end

            default: begin
                n_state = hsd_pkg::S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hsd_pkg::S_IDLE;
            r_phase     <= hsd_pkg::PH_SIZE_LO;
            r_alpha     <= '0;
            r_pad       <= 3'd0;
            r_placed    <= '0;
            r_sp        <= '0;
            r_nfree     <= '0;
            r_cur       <= '0;
            r_prev_leaf <= 1'b0;
            r_root_leaf <= 1'b0;
            r_sub       <= 1'b0;
            r_pend_v    <= 1'b0;
            r_out_v     <= 1'b0;
            r_rd_ok     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_alpha     <= n_alpha;
            r_pad       <= n_pad;
            r_placed    <= n_placed;
            r_sp        <= n_sp;
            r_nfree     <= n_nfree;
            r_cur       <= n_cur;
            r_prev_leaf <= n_prev_leaf;
            r_root_leaf <= n_root_leaf;
            r_sub       <= n_sub;
            r_pend_v    <= n_pend_v;
            r_out_v     <= n_out_v;
            // a read issued alongside a node store write returns stale data
            r_rd_ok     <= !(node_we || right_we);
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_size_lo  <= n_size_lo;
        r_byte     <= n_byte;
        r_last     <= n_last;
        r_bit      <= n_bit;
        r_nbits    <= n_nbits;
        r_pend_sym <= n_pend_sym;
        r_pend_st  <= n_pend_st;
        r_out_sym  <= n_out_sym;
        r_out_st   <= n_out_st;
        r_out_last <= n_out_last;
    end

    // symbol list and pending-right stack, each read into a register from its next-state address
    always_ff @(posedge i_clk) begin
        if (list_we) begin
            sym_list[r_placed[LW-1:0]] <= i_in.stream_byte;
        end
        if (push) begin
            stack_mem[r_sp[LW-1:0]] <= r_nfree;
        end
        r_sl  <= sym_list[n_placed[LW-1:0]];
        r_top <= push ? r_nfree : stack_mem[top_addr];
    end

`ifndef SYNTHESIS
    a_idle_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hsd_pkg::S_IDLE) |-> !r_pend_v)
        else $error("pending result left over in idle");

    a_stack_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= CW'(MAX_SYMBOLS))
        else $error("stack pointer beyond stack depth");

    a_walk_in_tree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == hsd_pkg::PH_DATA && r_nfree != '0) |-> (r_cur < r_nfree))
        else $error("walk left the built tree");

    a_split_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sub && r_state == hsd_pkg::S_BITS) |-> (r_phase == hsd_pkg::PH_TREE))
        else $error("split tree step outside tree phase");
`endif
endmodule

### bench/huffman_stream_decoder_tb.sv
// testbench of the huffman stream decoder: directed and random compressed streams,
// every decoded symbol checked against an in-bench decoder model
// depends on hsd_pkg, hsd_in_if, hsd_out_if and huffman_stream_decoder
module huffman_stream_decoder_tb;

    localparam int NODE_CAP  = 2 * hsd_pkg::MAX_SYMBOLS_DEF - 1;
    localparam int STACK_CAP = hsd_pkg::MAX_SYMBOLS_DEF;
    localparam int CYCLE_CAP = 800000;

    typedef struct packed {
        logic [7:0] symbol;
        logic [1:0] status;
        logic       run_last;
    } t_symbol_out;

    class hsd_scoreboard;
        hsd_pkg::t_phase phase;
        int          alpha_size, pad_cnt, placed, sp, free_node, walk_node;
        logic [7:0]  sym_list [hsd_pkg::MAX_SYMBOLS_DEF];
        int          lchild [NODE_CAP];
        int          rchild [NODE_CAP];
        bit          is_leaf [NODE_CAP];
        logic [7:0]  leaf_sym [NODE_CAP];
        int          right_todo [STACK_CAP];
        t_symbol_out decoded_q [$];
        t_symbol_out step_q [$];
        int          errors;

        function new();
            clear_stream();
            errors = 0;
        endfunction

        function void clear_stream();
            phase = hsd_pkg::PH_SIZE_LO;
            alpha_size = 0;
            pad_cnt = 0;
            placed = 0;
            sp = 0;
            free_node = 0;
            walk_node = 0;
        endfunction

        function void push_sym(logic [7:0] s, logic [1:0] st);
            t_symbol_out r;
            r.symbol = s;
            r.status = st;
            r.run_last = 1'b0;
            step_q.insert(step_q.size(), r);
        endfunction

        function void abort(logic [1:0] st);
            push_sym(8'd0, st);
            phase = hsd_pkg::PH_HALT;
        endfunction

        function void add_tree_bit(bit b);
            int n;
            int p;
            n = free_node;
            if (n >= NODE_CAP) begin
                abort(hsd_pkg::ST_BAD_TREE);
                return;
            end
            if (n > 0) begin
                if (!is_leaf[n-1]) begin
                    lchild[n-1] = n;
                end else begin
                    if (sp == 0) begin
                        abort(hsd_pkg::ST_BAD_TREE);
                        return;
                    end
                    sp--;
                    p = right_todo[sp];
                    rchild[p] = n;
                end
            end
            lchild[n] = 0;
            rchild[n] = 0;
            if (b) begin
                is_leaf[n] = 1;
                leaf_sym[n] = sym_list[placed % hsd_pkg::MAX_SYMBOLS_DEF];
                placed++;
                free_node = n + 1;
                if (placed >= alpha_size) begin
                    phase = hsd_pkg::PH_DATA;
                    walk_node = 0;
                end
            end else begin
                if (sp >= STACK_CAP) begin
                    abort(hsd_pkg::ST_BAD_TREE);
                    return;
                end
                is_leaf[n] = 0;
                leaf_sym[n] = 8'd0;
                right_todo[sp] = n;
                sp++;
                free_node = n + 1;
            end
        endfunction

        function void walk_bit(bit b);
            int child;
            if (free_node == 0) return;
            child = b ? rchild[walk_node] : lchild[walk_node];
            if (child == 0) begin
                walk_node = 0;
            end else if (is_leaf[child]) begin
                push_sym(leaf_sym[child], hsd_pkg::ST_OK);
                walk_node = 0;
            end else begin
                walk_node = child;
            end
        endfunction

        // work out the symbols one accepted byte produces
        function void note_item(logic [7:0] b, logic fin);
            int size;
            int nbits;
            step_q.delete();
            case (phase)
                hsd_pkg::PH_SIZE_LO: begin
                    alpha_size = b;
                    phase = hsd_pkg::PH_SIZE_HI;
                end
                hsd_pkg::PH_SIZE_HI: begin
                    size = (int'(b) << 8) | (alpha_size & 255);
                    if (size > hsd_pkg::MAX_SYMBOLS_DEF) begin
                        alpha_size = 0;
                        abort(hsd_pkg::ST_TOO_LARGE);
                    end else begin
                        alpha_size = size;
                        phase = hsd_pkg::PH_PAD;
                    end
                end
                hsd_pkg::PH_PAD: begin
                    pad_cnt = (b > 7) ? 7 : b;
                    placed = 0;
                    phase = (alpha_size == 0) ? hsd_pkg::PH_DATA : hsd_pkg::PH_LIST;
                end
                hsd_pkg::PH_LIST: begin
                    sym_list[placed % hsd_pkg::MAX_SYMBOLS_DEF] = b;
                    placed++;
                    if (placed >= alpha_size) begin
                        placed = 0;
                        sp = 0;
                        free_node = 0;
                        phase = hsd_pkg::PH_TREE;
                    end
                end
                hsd_pkg::PH_TREE, hsd_pkg::PH_DATA: begin
                    nbits = fin ? hsd_pkg::BYTE_BITS - pad_cnt : hsd_pkg::BYTE_BITS;
                    for (int i = 0; i < nbits; i++) begin
                        if (phase == hsd_pkg::PH_TREE) add_tree_bit(b[7-i]);
                        else if (phase == hsd_pkg::PH_DATA) walk_bit(b[7-i]);
                    end
                end
                default: ;
            endcase
            if (step_q.size() > 0) step_q[step_q.size()-1].run_last = 1'b1;
            foreach (step_q[i]) decoded_q.insert(decoded_q.size(), step_q[i]);
            if (fin) clear_stream();
        endfunction

        function void check_result(logic [7:0] s, logic [1:0] st, logic rl);
            t_symbol_out want;
            if (decoded_q.size() == 0) begin
                $display("%0t: unexpected result symbol %0d status %0d run_last %0d",
                         $time, s, st, rl);
                errors++;
                return;
            end
            want = decoded_q.pop_front();
            if (s !== want.symbol) begin
                $display("%0t: symbol expected %0d actual %0d", $time, want.symbol, s);
                errors++;
            end
            if (st !== want.status) begin
                $display("%0t: status expected %0d actual %0d", $time, want.status, st);
                errors++;
            end
            if (rl !== want.run_last) begin
                $display("%0t: run_last expected %0d actual %0d", $time, want.run_last, rl);
                errors++;
            end
        endfunction

        function int outstanding();
            return decoded_q.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    hsd_in_if  in_if();
    hsd_out_if out_if();

    huffman_stream_decoder u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    hsd_scoreboard sb;
    int  cycles;
    int  bytes_sent;
    bit  quiet;
    bit  hold_req;
    bit  hold_done;
    int  hold_left;

    logic [7:0] stream_q [$];
    bit         tree_bits [$];
    logic [255:0] sym_code [256];
    int           code_len [256];

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("tb: failure");
            $finish;
        end
    end

    // receiver: random stalls, plus one long hold-off to back up the block
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready = 1'b0;
        end else if (hold_left > 0) begin
            out_if.ready = 1'b0;
            hold_left--;
        end else if (hold_req && !hold_done) begin
            hold_done = 1;
            hold_left = 400;
            out_if.ready = 1'b0;
        end else begin
            out_if.ready = quiet ? 1'b1 : ($urandom_range(99) >= 15);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready)
            sb.check_result(out_if.symbol, out_if.status, out_if.run_last);
    end

    task automatic send_byte(logic [7:0] b, logic fin);
        if (!quiet && $urandom_range(99) < 15) begin
            in_if.valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        in_if.valid = 1'b1;
        in_if.stream_byte = b;
        in_if.final_byte = fin;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        sb.note_item(b, fin);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    // send the queued stream, final flag on its last byte
    task automatic send_stream();
        foreach (stream_q[i]) send_byte(stream_q[i], i == stream_q.size() - 1);
        stream_q.delete();
    endtask

    // random full binary tree with k leaves: preorder shape bits and leaf codes
    task automatic make_tree(int k);
        int           cnt_st [$];
        logic [255:0] pre_st [$];
        int           len_st [$];
        int           m, a, ln, leaf;
        logic [255:0] pre;
        tree_bits.delete();
        if (k == 0) return;
        cnt_st.push_front(k);
        pre_st.push_front('0);
        len_st.push_front(0);
        leaf = 0;
        while (cnt_st.size() > 0) begin
            m = cnt_st.pop_front();
            pre = pre_st.pop_front();
            ln = len_st.pop_front();
            if (m == 1) begin
                tree_bits.insert(tree_bits.size(), 1);
                sym_code[leaf] = pre;
                code_len[leaf] = ln;
                leaf++;
            end else begin
                tree_bits.insert(tree_bits.size(), 0);
                a = $urandom_range(1, m - 1);
                cnt_st.push_front(m - a);
                pre_st.push_front(pre | (256'd1 << ln));
                len_st.push_front(ln + 1);
                cnt_st.push_front(a);
                pre_st.push_front(pre);
                len_st.push_front(ln + 1);
            end
        end
    endtask

    // header, then the code bits packed msb first with the pad count of the tail
    task automatic pack_stream(int k, bit code_bits [$], logic [7:0] syms [$]);
        int         pad;
        logic [7:0] b;
        pad = (8 - code_bits.size() % 8) % 8;
        stream_q.insert(stream_q.size(), k[7:0]);
        stream_q.insert(stream_q.size(), k[15:8]);
        stream_q.insert(stream_q.size(),
                        (pad == 7 && $urandom_range(1)) ? 8'($urandom_range(8, 255))
                                                        : 8'(pad));
        foreach (syms[i]) stream_q.insert(stream_q.size(), syms[i]);
        while (code_bits.size() > 0) begin
            b = 8'($urandom);
            for (int i = 7; i >= 0; i--)
                if (code_bits.size() > 0) b[i] = code_bits.pop_front();
            stream_q.insert(stream_q.size(), b);
        end
    endtask

    task automatic good_stream(int k, int n_syms, bit sorted);
        bit         bits [$];
        logic [7:0] syms [$];
        int         s;
        for (int i = 0; i < k; i++) syms.insert(syms.size(), sorted ? 8'(i) : 8'($urandom));
        make_tree(k);
        bits = tree_bits;
        if (k > 1) begin
            for (int j = 0; j < n_syms; j++) begin
                s = $urandom_range(0, k - 1);
                for (int i = 0; i < code_len[s]; i++) bits.insert(bits.size(), sym_code[s][i]);
            end
        end else begin
            repeat (n_syms) bits.insert(bits.size(), bit'($urandom_range(1)));
        end
        pack_stream(k, bits, syms);
    endtask

    task automatic raw_stream(int n);
        repeat (n) stream_q.insert(stream_q.size(), 8'($urandom));
    endtask

    initial begin
        bit         bits [$];
        logic [7:0] syms [$];
        int         pick, k;
        sb = new();
        bytes_sent = 0;
        quiet = 0;
        hold_req = 0;
        i_rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.stream_byte = 8'd0;
        in_if.final_byte = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // two symbols, extreme values
        syms = '{8'h00, 8'hFF};
        bits = '{0, 1, 1, 0, 1, 1, 0, 0, 1, 0, 1, 1};
        pack_stream(2, bits, syms);
        send_stream();
        // one-symbol alphabet decodes nothing
        good_stream(1, 12, 0);
        send_stream();
        // empty alphabet
        good_stream(0, 16, 0);
        send_stream();
        // alphabet too large, then junk up to the final byte
        stream_q = '{8'h01, 8'h01, 8'hAA, 8'h55};
        send_stream();
        stream_q = '{8'hFF, 8'hFF, 8'h00};
        send_stream();
        // tree complete after its first leaf with symbols left over
        stream_q = '{8'h03, 8'h00, 8'h00, 8'h11, 8'h22, 8'h33, 8'hC0};
        send_stream();
        // final byte during the header
        stream_q = '{8'h05};
        send_stream();
        stream_q = '{8'h02, 8'h00};
        send_stream();
        // pending-right stack overflow: a long run of internal nodes
        syms.delete();
        bits.delete();
        for (int i = 0; i < 2; i++) syms.insert(syms.size(), 8'($urandom));
        repeat (264) bits.insert(bits.size(), 0);
        pack_stream(2, bits, syms);
        send_stream();

        // random streams, mostly well formed
        for (int n = 0; bytes_sent < 270; n++) begin
            quiet = (n >= 3 && n < 7);
            if (n == 1) hold_req = 1;
            pick = $urandom_range(99);
            k = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(2, 12);
            if (n == 1 || pick < 75) begin
                good_stream(k, (n == 1) ? 60 : $urandom_range(3, 30), 0);
            end else if (pick < 85) begin
                raw_stream($urandom_range(1, 10));
            end else begin
                // truncated stream, cut anywhere
                good_stream(k, $urandom_range(3, 20), 0);
                while (stream_q.size() > 1 && $urandom_range(3) != 0)
                    stream_q.delete(stream_q.size() - 1);
            end
            send_stream();
        end
        in_if.valid = 1'b0;
        quiet = 0;

        while (sb.outstanding() > 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
